// ----- hw/rtl/byte_bit_difference_counter_core_macros.svh -----
// ----------------------------------------------------------------------------
// Byte bit-difference counter assertion macros
// Concurrent assertion wrappers shared by the RTL; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BYTE_BIT_DIFFERENCE_COUNTER_CORE_MACROS_SVH
`define BYTE_BIT_DIFFERENCE_COUNTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BBDC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbdc: same-cycle check failed");
// next-cycle implication
`define BBDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbdc: next-cycle check failed");
`else
`define BBDC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BBDC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/bbdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte bit-difference counter package
// Field widths, register indexes, pipeline control type and byte popcount.
// ----------------------------------------------------------------------------
package bbdc_pkg;

  // fixed field widths
  localparam int BYTE_W      = 8;
  localparam int STREAM_W    = 64;
  localparam int VALID_W     = 4;
  localparam int LIMIT_W     = 48;
  localparam int OUT_BYTES_W = 48;
  localparam int OUT_BITS_W  = 51;
  localparam int POP_W       = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_BYTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT  = 2'd2;

  // control carried along the pipeline
  typedef struct packed {
    logic valid;
    logic first;
  } stage_ctrl_t;

  // number of set bits in one byte
  function automatic logic [POP_W-1:0] ones_in_byte(input logic [BYTE_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      n = n + POP_W'(v[k]);
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/bbdc_lane.sv -----
// ----------------------------------------------------------------------------
// Byte bit-difference lane
// XORs one byte of stream A with its partner and counts the differing bits.
// ----------------------------------------------------------------------------
module bbdc_lane (
  input  logic [bbdc_pkg::BYTE_W-1:0] a_byte,
  input  logic [bbdc_pkg::BYTE_W-1:0] b_byte,
  input  logic                        constant_mode,
  input  logic [bbdc_pkg::BYTE_W-1:0] constant_byte,
  output logic                        differs,
  output logic [bbdc_pkg::POP_W-1:0]  ones
);
  import bbdc_pkg::*;

  logic [BYTE_W-1:0] partner;
  logic [BYTE_W-1:0] x;

  // partner byte is either the stream B lane or the configured constant
  assign partner = constant_mode ? constant_byte : b_byte;
  assign x       = a_byte ^ partner;
  assign differs = |x;
  assign ones    = ones_in_byte(x);

endmodule

// ----- hw/rtl/bbdc_merge.sv -----
// ----------------------------------------------------------------------------
// Byte bit-difference lane merge stage
// Clamps the lane count and registers running prefix sums over the lanes.
// ----------------------------------------------------------------------------
module bbdc_merge #(
  parameter  int LANES = 8,
  localparam int LCW   = $clog2(LANES + 1),
  localparam int BCW   = $clog2(8 * LANES + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   first_of_run,
  input  logic [bbdc_pkg::VALID_W-1:0]           valid_bytes,
  input  logic [LANES-1:0]                       lane_differs,
  input  logic [LANES-1:0][bbdc_pkg::POP_W-1:0]  lane_ones,
  input  logic                                   take,
  output logic                                   in_stall,
  output bbdc_pkg::stage_ctrl_t                  s1,
  output logic [LCW-1:0]                         s1_lanes,
  output logic [LANES:0][LCW-1:0]                s1_pre_bytes,
  output logic [LANES:0][BCW-1:0]                s1_pre_bits
);
  import bbdc_pkg::*;

  logic [LCW-1:0]             lanes_clamped;
  logic [LANES:0][LCW-1:0]    pre_bytes;
  logic [LANES:0][BCW-1:0]    pre_bits;
  logic                       load;

  // lane counts beyond the lane array use every lane
  assign lanes_clamped = (valid_bytes > VALID_W'(LANES)) ? LCW'(LANES)
                                                         : LCW'(valid_bytes);

  // prefix k holds the totals over lanes 0..k-1
  always_comb begin
    pre_bytes[0] = '0;
    pre_bits[0]  = '0;
    for (int k = 0; k < LANES; k++) begin
      pre_bytes[k+1] = pre_bytes[k] + LCW'(lane_differs[k]);
      pre_bits[k+1]  = pre_bits[k] + BCW'(lane_ones[k]);
    end
  end

  // stage advances whenever it is empty or the accumulator takes its contents
  assign load     = !s1.valid || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (load) begin
      s1.valid <= in_valid;
      s1.first <= first_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_lanes     <= lanes_clamped;
      s1_pre_bytes <= pre_bytes;
      s1_pre_bits  <= pre_bits;
    end
  end

endmodule

// ----- hw/rtl/bbdc_accum.sv -----
// ----------------------------------------------------------------------------
// Byte bit-difference accumulator
// Applies the length limit, adds the lane sums into saturating running totals.
// ----------------------------------------------------------------------------
`include "byte_bit_difference_counter_core_macros.svh"

module bbdc_accum #(
  parameter  int LANES       = 8,
  parameter  int COUNT_WIDTH = 48,
  localparam int LCW         = $clog2(LANES + 1),
  localparam int BCW         = $clog2(8 * LANES + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bbdc_pkg::stage_ctrl_t              s1,
  input  logic [LCW-1:0]                     s1_lanes,
  input  logic [LANES:0][LCW-1:0]            s1_pre_bytes,
  input  logic [LANES:0][BCW-1:0]            s1_pre_bits,
  input  logic [bbdc_pkg::LIMIT_W-1:0]       length_limit,
  output logic                               take,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bbdc_pkg::OUT_BYTES_W-1:0]   total_bytes_compared,
  output logic [bbdc_pkg::OUT_BITS_W-1:0]    total_bits_compared,
  output logic [bbdc_pkg::OUT_BYTES_W-1:0]   total_bytes_differing,
  output logic [bbdc_pkg::OUT_BITS_W-1:0]    total_bits_differing,
  output logic                               limit_reached
);
  import bbdc_pkg::*;

  localparam int BITW = COUNT_WIDTH + 3;
  localparam int CMPW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  // running totals
  logic [COUNT_WIDTH-1:0] bytes_total;
  logic [COUNT_WIDTH-1:0] bytes_diff_total;
  logic [BITW-1:0]        bits_total;

  logic [COUNT_WIDTH-1:0] base_cmp;
  logic [COUNT_WIDTH-1:0] base_diff;
  logic [BITW-1:0]        base_bits;
  logic                   limit_nz;
  logic [CMPW:0]          room;
  logic                   room_neg;
  logic                   room_short;
  logic [LCW-1:0]         lanes_eff;
  logic [COUNT_WIDTH:0]   cmp_sum;
  logic [COUNT_WIDTH:0]   diff_sum;
  logic [BITW:0]          bits_sum;
  logic [COUNT_WIDTH-1:0] bytes_total_next;
  logic [COUNT_WIDTH-1:0] bytes_diff_total_next;
  logic [BITW-1:0]        bits_total_next;

  // first transaction of a run starts from zero
  assign base_cmp  = s1.first ? '0 : bytes_total;
  assign base_diff = s1.first ? '0 : bytes_diff_total;
  assign base_bits = s1.first ? '0 : bits_total;

  // room left under the limit; negative when the count is already past it
  assign limit_nz   = |length_limit;
  assign room       = {1'b0, CMPW'(length_limit)} - {1'b0, CMPW'(base_cmp)};
  assign room_neg   = room[CMPW];
  assign room_short = room_neg || (room[CMPW-1:0] < CMPW'(s1_lanes));

  always_comb begin
    if (!limit_nz || !room_short) begin
      lanes_eff = s1_lanes;
    end else if (room_neg) begin
      lanes_eff = '0;
    end else begin
      lanes_eff = room[LCW-1:0];
    end
  end

  // saturating adds of the selected prefix sums
  assign cmp_sum  = {1'b0, base_cmp} + (COUNT_WIDTH + 1)'(lanes_eff);
  assign diff_sum = {1'b0, base_diff} + (COUNT_WIDTH + 1)'(s1_pre_bytes[lanes_eff]);
  assign bits_sum = {1'b0, base_bits} + (BITW + 1)'(s1_pre_bits[lanes_eff]);

  assign bytes_total_next      = cmp_sum[COUNT_WIDTH]  ? '1 : cmp_sum[COUNT_WIDTH-1:0];
  assign bytes_diff_total_next = diff_sum[COUNT_WIDTH] ? '1 : diff_sum[COUNT_WIDTH-1:0];
  assign bits_total_next       = bits_sum[BITW]        ? '1 : bits_sum[BITW-1:0];

  // output register frees up when empty or when the result is taken
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      bytes_total      <= '0;
      bytes_diff_total <= '0;
      bits_total       <= '0;
    end else if (take) begin
      out_valid <= s1.valid;
      if (s1.valid) begin
        bytes_total      <= bytes_total_next;
        bytes_diff_total <= bytes_diff_total_next;
        bits_total       <= bits_total_next;
      end
    end
  end

  // result fields come straight from the totals, which hold while stalled
  assign total_bytes_compared  = OUT_BYTES_W'(bytes_total);
  assign total_bits_compared   = OUT_BITS_W'({bytes_total, 3'b000});
  assign total_bytes_differing = OUT_BYTES_W'(bytes_diff_total);
  assign total_bits_differing  = OUT_BITS_W'(bits_total);
  assign limit_reached         = limit_nz && (CMPW'(bytes_total) >= CMPW'(length_limit));

  // checks
  `BBDC_ASSERT_NEXT(a_totals_hold, clk, rst, out_valid && out_stall, $stable(bytes_total) && $stable(bits_total))
  `BBDC_ASSERT_IMPLIES(a_diff_le_cmp, clk, rst, 1'b1, bytes_diff_total <= bytes_total)
  `BBDC_ASSERT_NEXT(a_limit_kept, clk, rst, take && s1.valid && !s1.first && limit_nz && (CMPW'(bytes_total) <= CMPW'(length_limit)), CMPW'(bytes_total) <= CMPW'($past(length_limit)))

endmodule

// ----- hw/rtl/byte_bit_difference_counter_core.sv -----
// Path: a transaction passes the merge stage register, then the accumulator output register.
// Throughput: one transaction per cycle while out_stall does not hold the output; the limit
//   check, prefix select and saturating add of the running totals are combinational in the accumulator.
// Reset (rst, synchronous): clears the totals, the configuration registers and
//   both pipeline valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Byte bit-difference counter core
// Parallel byte lanes compare stream A to stream B or a constant byte and
// feed a merge stage and a saturating accumulator of bytes compared and bytes and bits differing.
// ----------------------------------------------------------------------------
module byte_bit_difference_counter_core #(
  parameter int LANES       = 8,
  parameter int COUNT_WIDTH = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write_en,
  input  logic [bbdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bbdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                first_of_run,
  input  logic [bbdc_pkg::STREAM_W-1:0]       stream_a_bytes,
  input  logic [bbdc_pkg::STREAM_W-1:0]       stream_b_bytes,
  input  logic [bbdc_pkg::VALID_W-1:0]        valid_bytes,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bbdc_pkg::OUT_BYTES_W-1:0]    total_bytes_compared,
  output logic [bbdc_pkg::OUT_BITS_W-1:0]     total_bits_compared,
  output logic [bbdc_pkg::OUT_BYTES_W-1:0]    total_bytes_differing,
  output logic [bbdc_pkg::OUT_BITS_W-1:0]     total_bits_differing,
  output logic                                limit_reached
);
  import bbdc_pkg::*;

  localparam int LCW = $clog2(LANES + 1);
  localparam int BCW = $clog2(8 * LANES + 1);

  // configuration registers
  logic               constant_mode;
  logic [BYTE_W-1:0]  constant_byte;
  logic [LIMIT_W-1:0] length_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      constant_mode <= 1'b0;
      constant_byte <= '0;
      length_limit  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_CONSTANT_MODE: constant_mode <= cfg_data[0];
        CFG_CONSTANT_BYTE: constant_byte <= cfg_data[BYTE_W-1:0];
        CFG_LENGTH_LIMIT:  length_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-lane compare
  logic [LANES-1:0]            lane_differs;
  logic [LANES-1:0][POP_W-1:0] lane_ones;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bbdc_lane u_lane (
      .a_byte        (stream_a_bytes[BYTE_W*i +: BYTE_W]),
      .b_byte        (stream_b_bytes[BYTE_W*i +: BYTE_W]),
      .constant_mode (constant_mode),
      .constant_byte (constant_byte),
      .differs       (lane_differs[i]),
      .ones          (lane_ones[i])
    );
  end

  // merge stage
  stage_ctrl_t             s1;
  logic [LCW-1:0]          s1_lanes;
  logic [LANES:0][LCW-1:0] s1_pre_bytes;
  logic [LANES:0][BCW-1:0] s1_pre_bits;
  logic                    take;

  bbdc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .first_of_run (first_of_run),
    .valid_bytes  (valid_bytes),
    .lane_differs (lane_differs),
    .lane_ones    (lane_ones),
    .take         (take),
    .in_stall     (in_stall),
    .s1           (s1),
    .s1_lanes     (s1_lanes),
    .s1_pre_bytes (s1_pre_bytes),
    .s1_pre_bits  (s1_pre_bits)
  );

  // accumulator and result register
  bbdc_accum #(
    .LANES       (LANES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk                   (clk),
    .rst                   (rst),
    .s1                    (s1),
    .s1_lanes              (s1_lanes),
    .s1_pre_bytes          (s1_pre_bytes),
    .s1_pre_bits           (s1_pre_bits),
    .length_limit          (length_limit),
    .take                  (take),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .total_bytes_compared  (total_bytes_compared),
    .total_bits_compared   (total_bits_compared),
    .total_bytes_differing (total_bytes_differing),
    .total_bits_differing  (total_bits_differing),
    .limit_reached         (limit_reached)
  );

endmodule
